/* rtl/bracketed_csv_command_parser_unit_macros.svh */
// Assertion macros for the bracketed CSV command parser.
// Included by the RTL files that carry concurrent checks; no other dependency.
`ifndef BRACKETED_CSV_COMMAND_PARSER_UNIT_MACROS_SVH
`define BRACKETED_CSV_COMMAND_PARSER_UNIT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, off during reset
`define BCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, off during reset
`define BCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/bcp_pkg.sv */
// Package for the bracketed CSV command parser: sizes, character codes,
// register indexes, frame kinds and the result beat type. No dependencies.
`default_nettype none

package bcp_pkg;

  localparam int unsigned MAX_CHARS  = 32;
  localparam int unsigned MAX_FIELDS = 4;
  localparam int unsigned TOKEN_CAP  = 16;

  localparam int unsigned CHAR_W  = $clog2(MAX_CHARS);
  localparam int unsigned SLOT_AW = $clog2(MAX_FIELDS);
  localparam int unsigned TOTAL_W = 5;
  localparam int unsigned VAL_W   = 16;

  localparam logic [7:0] OPEN_MARK  = 8'h5B;
  localparam logic [7:0] CLOSE_MARK = 8'h5D;
  localparam logic [7:0] SPLIT_MARK = 8'h2C;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  typedef enum logic [1:0] {
    CFG_ANGULAR_ID = 2'd0,
    CFG_FIRE_ID    = 2'd1,
    CFG_GAINS_ID   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_ANGULAR = 2'd0,
    KIND_FIRE    = 2'd1,
    KIND_GAINS   = 2'd2,
    KIND_OTHER   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [VAL_W-1:0]   package_id;
    logic [VAL_W-1:0]   value_one;
    logic [VAL_W-1:0]   value_two;
    logic [VAL_W-1:0]   value_three;
    logic [TOTAL_W-1:0] token_total;
    logic               too_many;
  } result_t;

endpackage

`default_nettype wire

/* rtl/bracketed_csv_command_parser_unit.sv */
// Bracketed CSV command parser: one received byte per input beat, one result
// beat per frame-ending bracket. Uses bcp_pkg and the assertion macro header.
//
// The parser takes one byte every cycle unless in_stall_o is high. Bytes outside
// a frame are ignored until '['; inside a frame the text is split on commas and
// each token is read as a decimal integer (leading blanks, optional sign, digits,
// wrapping to 16 bits) into the field slots. The byte is folded into the token
// state in the cycle it is accepted; the result for ']' goes to the output
// register, or to the skid register if an unread result is there. This two-entry
// buffer lets input keep flowing while one result waits; in_stall_o rises only
// when both entries hold results. The user must write the id registers through
// the cfg port only while the block is idle; the block does not enforce this.
`default_nettype none
`include "bracketed_csv_command_parser_unit_macros.svh"

module bracketed_csv_command_parser_unit (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       cfg_we_i,
  input  wire  [1:0]                cfg_index_i,
  input  wire  [15:0]               cfg_data_i,
  input  wire                       in_valid_i,
  output logic                      in_stall_o,
  input  wire  [7:0]                rx_byte_i,
  output logic                      out_valid_o,
  input  wire                       out_stall_i,
  output logic [1:0]                frame_kind_o,
  output logic signed [15:0]        package_id_o,
  output logic signed [15:0]        value_one_o,
  output logic signed [15:0]        value_two_o,
  output logic signed [15:0]        value_three_o,
  output logic [4:0]                token_total_o,
  output logic                      too_many_tokens_o
);

  typedef enum logic [1:0] {
    PH_BEFORE = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  localparam logic [bcp_pkg::CHAR_W-1:0] CHAR_LIMIT =
    bcp_pkg::CHAR_W'(bcp_pkg::MAX_CHARS - 1);
  localparam logic [bcp_pkg::TOTAL_W-1:0] SLOT_LIMIT =
    bcp_pkg::TOTAL_W'(bcp_pkg::MAX_FIELDS);
  localparam logic [bcp_pkg::TOTAL_W-1:0] TOKEN_LIMIT =
    bcp_pkg::TOTAL_W'(bcp_pkg::TOKEN_CAP);

  logic [15:0] angular_id_q, fire_id_q, gains_id_q;

  logic                          inside_frame_q, inside_frame_d;
  logic [bcp_pkg::CHAR_W-1:0]    char_count_q, char_count_d;
  logic                          text_ended_q, text_ended_d;
  logic [bcp_pkg::TOTAL_W-1:0]   slot_index_q, slot_index_d;
  logic [15:0]                   accumulator_q, accumulator_d;
  logic                          negative_sign_q, negative_sign_d;
  phase_e                        phase_q, phase_d;
  logic                          token_open_q, token_open_d;
  logic                          overflow_q, overflow_d;
  logic [15:0]                   slots_q [bcp_pkg::MAX_FIELDS];
  logic [15:0]                   slots_d [bcp_pkg::MAX_FIELDS];

  logic            in_accept;
  logic            push;
  logic            pop;
  logic            do_close;
  logic            do_take;
  logic            is_blank;
  logic            is_digit;
  logic [15:0]     token_value;
  bcp_pkg::kind_e  kind;
  bcp_pkg::result_t res;

  bcp_pkg::result_t out_q, skid_q;
  logic             out_valid_q, skid_valid_q;

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign pop        = out_valid_q && !out_stall_i;

  assign is_blank = (rx_byte_i == bcp_pkg::CH_SPACE) ||
                    ((rx_byte_i >= bcp_pkg::CH_TAB) && (rx_byte_i <= bcp_pkg::CH_CR));
  assign is_digit = (rx_byte_i >= bcp_pkg::CH_ZERO) && (rx_byte_i <= bcp_pkg::CH_NINE);
  assign token_value = negative_sign_q ? 16'(16'd0 - accumulator_q) : accumulator_q;

  always_comb begin
    inside_frame_d  = inside_frame_q;
    char_count_d    = char_count_q;
    text_ended_d    = text_ended_q;
    slot_index_d    = slot_index_q;
    accumulator_d   = accumulator_q;
    negative_sign_d = negative_sign_q;
    phase_d         = phase_q;
    token_open_d    = token_open_q;
    overflow_d      = overflow_q;
    slots_d         = slots_q;
    push            = 1'b0;
    do_close        = 1'b0;
    do_take         = 1'b0;

    if (in_accept) begin
      if (!inside_frame_q) begin
        if (rx_byte_i == bcp_pkg::OPEN_MARK) begin
          inside_frame_d  = 1'b1;
          char_count_d    = '0;
          text_ended_d    = 1'b0;
          slot_index_d    = '0;
          overflow_d      = 1'b0;
          accumulator_d   = '0;
          negative_sign_d = 1'b0;
          phase_d         = PH_BEFORE;
          token_open_d    = 1'b0;
        end
      end else if (rx_byte_i != bcp_pkg::CLOSE_MARK) begin
        if (char_count_q < CHAR_LIMIT) begin
          char_count_d = char_count_q + 1'b1;
          if (!text_ended_q) begin
            priority if (rx_byte_i == bcp_pkg::CH_NUL) begin
              text_ended_d = 1'b1;
            end else if (rx_byte_i == bcp_pkg::SPLIT_MARK) begin
              do_close = 1'b1;
            end else begin
              do_take = 1'b1;
            end
          end
        end
      end else begin
        do_close       = 1'b1;
        push           = 1'b1;
        inside_frame_d = 1'b0;
        char_count_d   = '0;
        text_ended_d   = 1'b0;
      end
    end

    if (do_close) begin
      if (token_open_q) begin
        if (slot_index_q < SLOT_LIMIT) begin
          slots_d[slot_index_q[bcp_pkg::SLOT_AW-1:0]] = token_value;
        end else begin
          overflow_d = 1'b1;
        end
        if (slot_index_q < TOKEN_LIMIT) begin
          slot_index_d = slot_index_q + 1'b1;
        end
      end
      accumulator_d   = '0;
      negative_sign_d = 1'b0;
      phase_d         = PH_BEFORE;
      token_open_d    = 1'b0;
    end

    if (do_take) begin
      token_open_d = 1'b1;
      priority if (phase_q == PH_BEFORE && is_blank) begin
        phase_d = PH_BEFORE;
      end else if (phase_q == PH_BEFORE && rx_byte_i == bcp_pkg::CH_PLUS) begin
        phase_d = PH_SIGN;
      end else if (phase_q == PH_BEFORE && rx_byte_i == bcp_pkg::CH_MINUS) begin
        negative_sign_d = 1'b1;
        phase_d         = PH_SIGN;
      end else if (phase_q != PH_DONE) begin
        if (is_digit) begin
          accumulator_d = (accumulator_q << 3) + (accumulator_q << 1) +
                          {12'd0, rx_byte_i[3:0]};
          phase_d       = PH_DIGITS;
        end else begin
          phase_d = PH_DONE;
        end
      end else begin
        phase_d = PH_DONE;
      end
    end
  end

  always_comb begin
    priority if (slots_d[0] == angular_id_q) begin
      kind = bcp_pkg::KIND_ANGULAR;
    end else if (slots_d[0] == fire_id_q) begin
      kind = bcp_pkg::KIND_FIRE;
    end else if (slots_d[0] == gains_id_q) begin
      kind = bcp_pkg::KIND_GAINS;
    end else begin
      kind = bcp_pkg::KIND_OTHER;
    end
    res.kind        = kind;
    res.package_id  = slots_d[0];
    res.value_one   = slots_d[1];
    res.value_two   = slots_d[2];
    res.value_three = slots_d[3];
    res.token_total = slot_index_d;
    res.too_many    = overflow_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angular_id_q <= 16'd0;
      fire_id_q    <= 16'd1;
      gains_id_q   <= 16'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bcp_pkg::CFG_ANGULAR_ID: angular_id_q <= cfg_data_i;
        bcp_pkg::CFG_FIRE_ID:    fire_id_q    <= cfg_data_i;
        bcp_pkg::CFG_GAINS_ID:   gains_id_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_frame_q  <= 1'b0;
      char_count_q    <= '0;
      text_ended_q    <= 1'b0;
      slot_index_q    <= '0;
      accumulator_q   <= '0;
      negative_sign_q <= 1'b0;
      phase_q         <= PH_BEFORE;
      token_open_q    <= 1'b0;
      overflow_q      <= 1'b0;
      for (int i = 0; i < bcp_pkg::MAX_FIELDS; i++) begin
        slots_q[i] <= '0;
      end
    end else begin
      inside_frame_q  <= inside_frame_d;
      char_count_q    <= char_count_d;
      text_ended_q    <= text_ended_d;
      slot_index_q    <= slot_index_d;
      accumulator_q   <= accumulator_d;
      negative_sign_q <= negative_sign_d;
      phase_q         <= phase_d;
      token_open_q    <= token_open_d;
      overflow_q      <= overflow_d;
      slots_q         <= slots_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign frame_kind_o      = out_q.kind;
  assign package_id_o      = signed'(out_q.package_id);
  assign value_one_o       = signed'(out_q.value_one);
  assign value_two_o       = signed'(out_q.value_two);
  assign value_three_o     = signed'(out_q.value_three);
  assign token_total_o     = out_q.token_total;
  assign too_many_tokens_o = out_q.too_many;

  `BCP_ASSERT_IMP(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  `BCP_ASSERT_IMP(a_count_in_range, clk_i, rst_ni, 1'b1, char_count_q <= CHAR_LIMIT)
  `BCP_ASSERT_IMP(a_idle_text_clear, clk_i, rst_ni, !inside_frame_q,
                  char_count_q == '0 && !text_ended_q)
  `BCP_ASSERT_IMP(a_total_capped, clk_i, rst_ni, out_valid_q,
                  out_q.token_total <= TOKEN_LIMIT)
  `BCP_ASSERT_NXT(a_close_gives_beat, clk_i, rst_ni,
                  in_accept && inside_frame_q && rx_byte_i == bcp_pkg::CLOSE_MARK,
                  out_valid_q)

endmodule

`default_nettype wire

/* tb/tb_bracketed_csv_command_parser_unit.sv */
// Self-checking testbench for bracketed_csv_command_parser_unit: byte stream in,
// one checked result beat per frame-ending bracket, several id register settings.
// Depends on bcp_pkg and the parser RTL only.
`timescale 1ns / 100ps

module tb_bracketed_csv_command_parser_unit;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } token_phase_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = bcp_pkg::CFG_ANGULAR_ID;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic [7:0] rx_byte = '0;
  logic out_stall = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic [1:0] frame_kind_o;
  logic signed [15:0] package_id_o;
  logic signed [15:0] value_one_o;
  logic signed [15:0] value_two_o;
  logic signed [15:0] value_three_o;
  logic [4:0] token_total_o;
  logic too_many_tokens_o;

  // parser mirror
  logic [15:0] id_regs [3];
  logic in_frame;
  logic [5:0] char_cnt;
  logic text_done;
  logic [4:0] tok_cnt;
  logic [15:0] tok_acc;
  logic tok_neg;
  token_phase_e tok_phase;
  logic tok_open;
  logic [15:0] slots [bcp_pkg::MAX_FIELDS];
  logic dropped;

  logic [7:0] pend_bytes [$];
  bcp_pkg::result_t expected_frames [$];
  bcp_pkg::result_t want_frame;
  bit calm = 1'b0;
  int error_count = 0;
  int beats_sent = 0;
  int frames_checked = 0;
  int overflow_frames = 0;
  int settings_used = 1;
  int kind_count [4] = '{0, 0, 0, 0};
  int cycle_count = 0;

  bracketed_csv_command_parser_unit DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall_o),
    .rx_byte_i         (rx_byte),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall),
    .frame_kind_o      (frame_kind_o),
    .package_id_o      (package_id_o),
    .value_one_o       (value_one_o),
    .value_two_o       (value_two_o),
    .value_three_o     (value_three_o),
    .token_total_o     (token_total_o),
    .too_many_tokens_o (too_many_tokens_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic void clear_token();
    tok_acc = '0;
    tok_neg = 1'b0;
    tok_phase = PH_LEAD;
    tok_open = 1'b0;
  endfunction

  function automatic void close_token();
    logic [15:0] v;
    if (tok_open) begin
      v = tok_neg ? (16'd0 - tok_acc) : tok_acc;
      if (tok_cnt < bcp_pkg::MAX_FIELDS) slots[tok_cnt] = v;
      else dropped = 1'b1;
      if (tok_cnt < bcp_pkg::TOKEN_CAP) tok_cnt = tok_cnt + 5'd1;
    end
    clear_token();
  endfunction

  function automatic void take_char(logic [7:0] c);
    logic is_digit;
    is_digit = (c >= bcp_pkg::CH_ZERO) && (c <= bcp_pkg::CH_NINE);
    tok_open = 1'b1;
    if (tok_phase == PH_LEAD) begin
      if (c == bcp_pkg::CH_SPACE || (c >= bcp_pkg::CH_TAB && c <= bcp_pkg::CH_CR)) return;
      if (c == bcp_pkg::CH_PLUS) begin
        tok_phase = PH_SIGN;
        return;
      end
      if (c == bcp_pkg::CH_MINUS) begin
        tok_neg = 1'b1;
        tok_phase = PH_SIGN;
        return;
      end
    end
    if (tok_phase != PH_DONE) begin
      if (is_digit) begin
        tok_acc = tok_acc * 16'd10 + {8'd0, c} - {8'd0, bcp_pkg::CH_ZERO};
        tok_phase = PH_DIGITS;
      end else begin
        tok_phase = PH_DONE;
      end
    end
  endfunction

  function automatic void parse_byte(logic [7:0] c);
    bcp_pkg::result_t r;
    if (!in_frame) begin
      if (c == bcp_pkg::OPEN_MARK) begin
        in_frame = 1'b1;
        char_cnt = '0;
        text_done = 1'b0;
        tok_cnt = '0;
        dropped = 1'b0;
        clear_token();
      end
    end else if (c != bcp_pkg::CLOSE_MARK) begin
      if (char_cnt < bcp_pkg::MAX_CHARS - 1) begin
        char_cnt = char_cnt + 6'd1;
        if (!text_done) begin
          if (c == bcp_pkg::CH_NUL) text_done = 1'b1;
          else if (c == bcp_pkg::SPLIT_MARK) close_token();
          else take_char(c);
        end
      end
    end else begin
      close_token();
      in_frame = 1'b0;
      char_cnt = '0;
      text_done = 1'b0;
      if (slots[0] == id_regs[bcp_pkg::CFG_ANGULAR_ID]) r.kind = bcp_pkg::KIND_ANGULAR;
      else if (slots[0] == id_regs[bcp_pkg::CFG_FIRE_ID]) r.kind = bcp_pkg::KIND_FIRE;
      else if (slots[0] == id_regs[bcp_pkg::CFG_GAINS_ID]) r.kind = bcp_pkg::KIND_GAINS;
      else r.kind = bcp_pkg::KIND_OTHER;
      r.package_id = slots[0];
      r.value_one = slots[1];
      r.value_two = slots[2];
      r.value_three = slots[3];
      r.token_total = tok_cnt;
      r.too_many = dropped;
      expected_frames.push_back(r);
    end
  endfunction

  // driver: hold the beat while stalled; otherwise idle at random unless calm
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        parse_byte(rx_byte);
        beats_sent++;
      end
      if (!in_valid || !in_stall_o) begin
        if (pend_bytes.size() > 0 && (calm || $urandom_range(0, 99) >= 30)) begin
          in_valid <= 1'b1;
          rx_byte <= pend_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      frames_checked++;
      if (expected_frames.size() == 0) begin
        report_error("result beat with no frame pending");
      end else begin
        want_frame = expected_frames.pop_front();
        kind_count[want_frame.kind]++;
        if (want_frame.too_many) overflow_frames++;
        if (frame_kind_o !== want_frame.kind)
          report_error($sformatf("frame_kind got %0d want %0d", frame_kind_o, want_frame.kind));
        if (package_id_o !== want_frame.package_id)
          report_error($sformatf("package_id got %0d want %0d", package_id_o,
                                 $signed(want_frame.package_id)));
        if (value_one_o !== want_frame.value_one)
          report_error($sformatf("value_one got %0d want %0d", value_one_o,
                                 $signed(want_frame.value_one)));
        if (value_two_o !== want_frame.value_two)
          report_error($sformatf("value_two got %0d want %0d", value_two_o,
                                 $signed(want_frame.value_two)));
        if (value_three_o !== want_frame.value_three)
          report_error($sformatf("value_three got %0d want %0d", value_three_o,
                                 $signed(want_frame.value_three)));
        if (token_total_o !== want_frame.token_total)
          report_error($sformatf("token_total got %0d want %0d", token_total_o,
                                 want_frame.token_total));
        if (too_many_tokens_o !== want_frame.too_many)
          report_error($sformatf("too_many_tokens got %0b want %0b", too_many_tokens_o,
                                 want_frame.too_many));
      end
    end
    out_stall <= !calm && ($urandom_range(0, 99) < 30);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) pend_bytes.push_back(s[i]);
  endtask

  task automatic write_id(bcp_pkg::cfg_idx_e idx, logic [15:0] v);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    id_regs[idx] = v;
  endtask

  task automatic drain();
    while (pend_bytes.size() > 0 || in_valid || expected_frames.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_id();
    case ($urandom_range(0, 3))
      0: return id_regs[bcp_pkg::CFG_ANGULAR_ID];
      1: return id_regs[bcp_pkg::CFG_FIRE_ID];
      2: return id_regs[bcp_pkg::CFG_GAINS_ID];
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic string make_token(logic [15:0] v);
    string s;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return "   ";
    if (pick == 1) return "-x";
    if (pick == 2) return "q9";
    case ($urandom_range(0, 5))
      0: s = " ";
      1: s = "\t ";
      2: s = "\015\012";
      default: s = "";
    endcase
    if (pick == 3) s = {s, $sformatf("%0d", $urandom_range(65536, 999999))};
    else if (!v[15] && $urandom_range(0, 3) == 0) s = {s, "+", $sformatf("%0d", v)};
    else s = {s, $sformatf("%0d", $signed(v))};
    if ($urandom_range(0, 7) == 0) s = {s, "z1"};
    return s;
  endfunction

  task automatic queue_frame();
    logic [7:0] b;
    int shape;
    int n_tok;
    if ($urandom_range(0, 9) == 0) pend_bytes.push_back(bcp_pkg::CLOSE_MARK);
    repeat ($urandom_range(0, 2)) begin
      b = 8'($urandom);
      if (b != bcp_pkg::OPEN_MARK) pend_bytes.push_back(b);
    end
    pend_bytes.push_back(bcp_pkg::OPEN_MARK);
    shape = $urandom_range(0, 99);
    if (shape < 8) begin
      repeat ($urandom_range(12, 20)) queue_text($sformatf("%0d,", $urandom_range(0, 9)));
    end else if (shape < 18) begin
      repeat ($urandom_range(1, 40)) begin
        b = 8'($urandom);
        if (b != bcp_pkg::CLOSE_MARK) pend_bytes.push_back(b);
      end
    end else begin
      n_tok = $urandom_range(1, 6);
      for (int i = 0; i < n_tok; i++) begin
        if (i > 0) queue_text(($urandom_range(0, 5) == 0) ? ",," : ",");
        queue_text(make_token((i == 0) ? pick_id() : 16'($urandom)));
      end
      if ($urandom_range(0, 9) == 0) begin
        pend_bytes.push_back(bcp_pkg::CH_NUL);
        queue_text(",5");
      end
    end
    pend_bytes.push_back(bcp_pkg::CLOSE_MARK);
  endtask

  task automatic queue_random(int n_bytes);
    int target;
    target = pend_bytes.size() + n_bytes;
    while (pend_bytes.size() < target) queue_frame();
  endtask

  initial begin
    id_regs[bcp_pkg::CFG_ANGULAR_ID] = 16'd0;
    id_regs[bcp_pkg::CFG_FIRE_ID] = 16'd1;
    id_regs[bcp_pkg::CFG_GAINS_ID] = 16'd2;
    in_frame = 1'b0;
    char_cnt = '0;
    text_done = 1'b0;
    tok_cnt = '0;
    dropped = 1'b0;
    clear_token();
    for (int i = 0; i < bcp_pkg::MAX_FIELDS; i++) slots[i] = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // stray close, '[' inside text, sign forms, empty and junk tokens, slot overflow
    queue_text("]A[ 1,-2,+65535,,x,[3]");
    // extreme byte values and early end of text
    pend_bytes.push_back(bcp_pkg::OPEN_MARK);
    pend_bytes.push_back(8'hFF);
    queue_text("2");
    pend_bytes.push_back(bcp_pkg::CH_NUL);
    queue_text(",9]");
    drain();

    write_id(bcp_pkg::CFG_ANGULAR_ID, 16'h8000);
    write_id(bcp_pkg::CFG_FIRE_ID, 16'h7FFF);
    write_id(bcp_pkg::CFG_GAINS_ID, 16'hFFFF);
    settings_used++;
    queue_random(250);
    drain();

    // all ids equal: angular takes priority
    write_id(bcp_pkg::CFG_ANGULAR_ID, 16'd5);
    write_id(bcp_pkg::CFG_FIRE_ID, 16'd5);
    write_id(bcp_pkg::CFG_GAINS_ID, 16'd5);
    settings_used++;
    queue_random(250);
    drain();

    write_id(bcp_pkg::CFG_ANGULAR_ID, 16'd3);
    write_id(bcp_pkg::CFG_FIRE_ID, 16'hFFF9);
    write_id(bcp_pkg::CFG_GAINS_ID, 16'hFFF9);
    settings_used++;
    queue_random(250);
    drain();

    write_id(bcp_pkg::CFG_ANGULAR_ID, 16'($urandom));
    write_id(bcp_pkg::CFG_FIRE_ID, 16'($urandom));
    write_id(bcp_pkg::CFG_GAINS_ID, 16'($urandom));
    settings_used++;
    calm = 1'b1;
    queue_random(250);
    drain();

    while (expected_frames.size() > 0) begin
      want_frame = expected_frames.pop_front();
      report_error($sformatf("frame with id %0d never reported", $signed(want_frame.package_id)));
    end
    $display("Sent %0d bytes, checked %0d frames under %0d id settings, %0d with overflow",
             beats_sent, frames_checked, settings_used, overflow_frames);
    $display("Frames by kind: angular %0d, fire %0d, gains %0d, other %0d",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/bcp_pkg.sv
rtl/bracketed_csv_command_parser_unit.sv
tb/tb_bracketed_csv_command_parser_unit.sv
